// ===== rtl/gelu_pkg.sv =====
// ----------------------------------------------------------------------------
// gelu_pkg
// Widths, fixed-point constants and the tanh breakpoint table for the GELU
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gelu_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int FRAC_BITS     = 12;
  localparam int TANH_SEGMENTS = 64;
  localparam int SEG_BITS      = $clog2(TANH_SEGMENTS);
  localparam int ROM_AW        = $clog2(TANH_SEGMENTS + 1);

  localparam int WORK_FRAC = 16;
  localparam int LIMIT_W   = WORK_FRAC + 2;
  localparam int AW_SH     = WORK_FRAC - FRAC_BITS;
  localparam int A2_W      = 2 * LIMIT_W - WORK_FRAC;
  localparam int A3_W      = A2_W + LIMIT_W - WORK_FRAC;
  localparam int KC_W      = 26;
  localparam int KS_W      = 30;
  localparam int K_SH      = 30;
  localparam int C_W       = KC_W + A3_W - K_SH;
  localparam int S_W       = LIMIT_W + 1;
  localparam int U_W       = KS_W + S_W - K_SH;
  localparam int T_W       = WORK_FRAC + 1;
  localparam int F_W       = WORK_FRAC + 2;
  localparam int MAG_W     = DATA_WIDTH + F_W + 1 - (WORK_FRAC + 1);

  localparam logic [KC_W-1:0]      K_CUBE   = KC_W'(48012366);
  localparam logic [KS_W-1:0]      K_SCALE  = KS_W'(856722024);
  localparam logic [T_W-1:0]       WORK_ONE = T_W'(65536);
  localparam logic [63:0]          EXP_ONE  = 64'd16777216;

  typedef logic [WORK_FRAC-1:0] tanh_rom_t [TANH_SEGMENTS+1];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(4*i/TANH_SEGMENTS) in Q.16: series for e^g, squared three times
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   rom;
    logic [63:0] g;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    for (int i = 0; i <= TANH_SEGMENTS; i++) begin
      g    = (64'(i) << 24) >> SEG_BITS;
      term = EXP_ONE;
      sum  = EXP_ONE;
      for (int k = 1; k <= 20; k++) begin
        term = udiv64((term * g) >> 24, 64'(k));
        sum  = sum + term;
      end
      e = sum;
      for (int k = 0; k < 3; k++) begin
        e = (e * e + (EXP_ONE >> 1)) >> 24;
      end
      den    = e + EXP_ONE;
      num    = ((e - EXP_ONE) << 16) + (den >> 1);
      q      = udiv64(num, den);
      rom[i] = q[WORK_FRAC-1:0];
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

// ===== rtl/gelu_tanh_activation.sv =====
// ----------------------------------------------------------------------------
// gelu_tanh_activation
// GELU, tanh form, on signed Q4.12 words with a piecewise-linear tanh.
// Throughput: one word per cycle; a nine-stage pipeline with one global
// enable, frozen only while the output register holds an untaken word.
// Reset clears all stage valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module gelu_tanh_activation
  import gelu_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         x_valid_i,
  output      logic                         x_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0] x_value_i,
  input  wire logic                         last_in_i,
  output      logic                         y_valid_o,
  input  wire logic                         y_ready_i,
  output      logic signed [DATA_WIDTH-1:0] y_value_o,
  output      logic                         last_out_o
);

  localparam int NST = 9;
  localparam logic [DATA_WIDTH-1:0] BIG_A = DATA_WIDTH'((64'd1 << LIMIT_W) >> AW_SH);

  logic en;

  logic                  vld_q  [NST];
  logic                  last_q [NST];
  logic                  neg_q  [8];
  logic [DATA_WIDTH-1:0] a_q    [7];
  logic                  big_q  [5];

  logic [A2_W-1:0]       a2_q;
  logic [A3_W-1:0]       a3_q;
  logic [S_W-1:0]        s_q;
  logic [U_W-1:0]        u_q;
  logic [WORK_FRAC-1:0]  lo_q, diff_q;
  logic [LIMIT_W-1:0]    w_q;
  logic                  sat_q;
  logic [T_W-1:0]        t_q;
  logic [MAG_W-1:0]      mag_q;
  logic [DATA_WIDTH-1:0] y_q;

  logic                  neg_d;
  logic [DATA_WIDTH-1:0] a_d;
  logic [A2_W-1:0]       a2_d;
  logic [A3_W-1:0]       a3_d;
  logic [S_W-1:0]        s_d;
  logic [U_W-1:0]        u_d;
  logic [WORK_FRAC-1:0]  lo_d, diff_d;
  logic [LIMIT_W-1:0]    w_d;
  logic                  sat_d;
  logic [T_W-1:0]        t_d;
  logic [MAG_W-1:0]      mag_d;
  logic [DATA_WIDTH-1:0] y_d;

  logic [LIMIT_W-1:0]             aw0, aw1, aw2;
  logic [2*LIMIT_W-1:0]           sq;
  logic [A2_W+LIMIT_W-1:0]        cube;
  logic [KC_W+A3_W-1:0]           cprod;
  logic [S_W+KS_W-1:0]            uprod;
  logic [ROM_AW-1:0]              idx;
  logic [WORK_FRAC-1:0]           hi;
  logic [WORK_FRAC+LIMIT_W-1:0]   lprod;
  logic [F_W-1:0]                 factor;
  logic [DATA_WIDTH+F_W:0]        mprod;
  logic [MAG_W-1:0]               mag_c;

  assign en        = !vld_q[NST-1] || y_ready_i;
  assign x_ready_o = en;

  assign aw0 = LIMIT_W'({a_q[0], {AW_SH{1'b0}}});
  assign aw1 = LIMIT_W'({a_q[1], {AW_SH{1'b0}}});
  assign aw2 = LIMIT_W'({a_q[2], {AW_SH{1'b0}}});

  always_comb begin
    neg_d = x_value_i[DATA_WIDTH-1];
    a_d   = neg_d ? (~DATA_WIDTH'(x_value_i) + DATA_WIDTH'(1)) : DATA_WIDTH'(x_value_i);

    sq   = (2*LIMIT_W)'(aw0) * (2*LIMIT_W)'(aw0);
    a2_d = sq[2*LIMIT_W-1:WORK_FRAC];

    cube = (A2_W+LIMIT_W)'(a2_q) * (A2_W+LIMIT_W)'(aw1);
    a3_d = cube[A2_W+LIMIT_W-1:WORK_FRAC];

    cprod = (KC_W+A3_W)'(K_CUBE) * (KC_W+A3_W)'(a3_q);
    s_d   = S_W'(aw2) + S_W'(cprod[KC_W+A3_W-1:K_SH]);

    uprod = (S_W+KS_W)'(K_SCALE) * (S_W+KS_W)'(s_q);
    u_d   = uprod[S_W+KS_W-1:K_SH];

    sat_d  = big_q[4] || u_q[U_W-1];
    idx    = ROM_AW'(u_q[LIMIT_W-1 -: SEG_BITS]);
    lo_d   = TANH_ROM[idx];
    hi     = TANH_ROM[idx + ROM_AW'(1)];
    diff_d = (hi >= lo_d) ? (hi - lo_d) : '0;
    w_d    = {u_q[LIMIT_W-SEG_BITS-1:0], {SEG_BITS{1'b0}}};

    lprod = (WORK_FRAC+LIMIT_W)'(diff_q) * (WORK_FRAC+LIMIT_W)'(w_q);
    t_d   = sat_q ? WORK_ONE
                  : (T_W'(lo_q) + T_W'(lprod[WORK_FRAC+LIMIT_W-1:LIMIT_W]));

    factor = neg_q[6] ? (F_W'(WORK_ONE) - F_W'(t_q)) : (F_W'(WORK_ONE) + F_W'(t_q));
    mprod  = (DATA_WIDTH+F_W+1)'(a_q[6]) * (DATA_WIDTH+F_W+1)'(factor)
           + (DATA_WIDTH+F_W+1)'(WORK_ONE);
    mag_d  = mprod[DATA_WIDTH+F_W:WORK_FRAC+1];

    if (neg_q[7]) begin
      mag_c = (mag_q > MAG_W'(64'd1 << (DATA_WIDTH-1)))
            ? MAG_W'(64'd1 << (DATA_WIDTH-1)) : mag_q;
      y_d   = DATA_WIDTH'(MAG_W'(0) - mag_c);
    end else begin
      mag_c = (mag_q > MAG_W'((64'd1 << (DATA_WIDTH-1)) - 1))
            ? MAG_W'((64'd1 << (DATA_WIDTH-1)) - 1) : mag_q;
      y_d   = DATA_WIDTH'(mag_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= x_valid_i;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q[0] <= last_in_i;
      for (int k = 1; k < NST; k++) last_q[k] <= last_q[k-1];
      neg_q[0] <= neg_d;
      for (int k = 1; k < 8; k++) neg_q[k] <= neg_q[k-1];
      a_q[0] <= a_d;
      for (int k = 1; k < 7; k++) a_q[k] <= a_q[k-1];
      big_q[0] <= (a_d >= BIG_A);
      for (int k = 1; k < 5; k++) big_q[k] <= big_q[k-1];
      a2_q   <= a2_d;
      a3_q   <= a3_d;
      s_q    <= s_d;
      u_q    <= u_d;
      sat_q  <= sat_d;
      lo_q   <= lo_d;
      diff_q <= diff_d;
      w_q    <= w_d;
      t_q    <= t_d;
      mag_q  <= mag_d;
      y_q    <= y_d;
    end
  end

  assign y_valid_o  = vld_q[NST-1];
  assign y_value_o  = y_q;
  assign last_out_o = last_q[NST-1];

endmodule

`default_nettype wire
